FILE: hdl/rbst_pkg.sv
// Shared constants for the ray/box slab test.
`timescale 1ns / 1ps
package rbst_pkg;
  localparam int AXES  = 3;
  localparam int LANES = 2 * AXES;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [2:0] REG_DIRECTION_X = 3'd3;
  localparam logic [2:0] REG_DIRECTION_Y = 3'd4;
  localparam logic [2:0] REG_DIRECTION_Z = 3'd5;
endpackage

FILE: hdl/rbst_lane.sv
// One slab lane: pipelined saturating fixed-point quotient (corner - origin) / direction.
`timescale 1ns / 1ps
module rbst_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] corner,
  input  logic signed [W-1:0] origin,
  input  logic signed [W-1:0] direction,
  output logic signed [W-1:0] quot
);
  localparam int N = W + 1 + F;

  logic signed [W:0] diff_r;
  logic              dneg_r;
  logic [W-1:0]      dm_r;
  logic [W-1:0]      rem_r [0:N];
  logic [N-1:0]      dvd_r [0:N];
  logic [N-1:0]      q_r   [0:N];
  logic              neg_r [0:N];
  logic signed [W-1:0] quot_r;
  logic [W:0]        mag;
  logic [N-1:0]      cap;

  assign mag = diff_r[W] ? (W+1)'(-diff_r) : diff_r;
  assign cap = N'(1) << (W - 1);

  // operand setup
  always_ff @(posedge clk) begin
    if (en) begin
      diff_r   <= {corner[W-1], corner} - {origin[W-1], origin};
      dneg_r   <= direction[W-1];
      dm_r     <= direction[W-1] ? W'(-direction) : direction;
      rem_r[0] <= '0;
      dvd_r[0] <= N'(mag) << F;
      q_r[0]   <= '0;
      neg_r[0] <= diff_r[W] ^ dneg_r;
    end
  end

  // one quotient bit per stage, restoring division
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W:0] trial;
    logic       fit;
    assign trial = {rem_r[k], dvd_r[k][N-1]};
    assign fit   = trial >= {1'b0, dm_r};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= fit ? W'(trial - {1'b0, dm_r}) : W'(trial);
        dvd_r[k+1] <= {dvd_r[k][N-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][N-2:0], fit};
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // sign and saturate to the coordinate range
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[N]) quot_r <= (q_r[N] > cap) ? W'(cap) : W'(-q_r[N]);
      else          quot_r <= (q_r[N] > cap - N'(1)) ? W'(cap - N'(1)) : W'(q_r[N]);
    end
  end

  assign quot = quot_r;
endmodule

FILE: hdl/rbst_merge.sv
// Merge stage: orders per-axis slab bounds and narrows the parameter interval.
`timescale 1ns / 1ps
module rbst_merge #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] quot [0:rbst_pkg::LANES-1],
  input  logic [rbst_pkg::AXES-1:0] dzero,
  input  logic                zmiss,
  input  logic signed [W-1:0] t_lo,
  input  logic signed [W-1:0] t_hi,
  output logic                hit
);
  localparam logic signed [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};

  logic signed [W-1:0] e_r [0:rbst_pkg::AXES-1];
  logic signed [W-1:0] x_r [0:rbst_pkg::AXES-1];
  logic signed [W-1:0] lo_r, hi_r, lo1_r, hi1_r, lo_max, hi_min;
  logic                miss_r, miss1_r;

  // order entry/exit per axis; unbounded axes drop out
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
        logic signed [W-1:0] q0, q1;
        q0 = quot[a];
        q1 = quot[a + rbst_pkg::AXES];
        if (dzero[a]) begin
          e_r[a] <= TMIN;
          x_r[a] <= TMAX;
        end else begin
          e_r[a] <= (q0 > q1) ? q1 : q0;
          x_r[a] <= (q0 > q1) ? q0 : q1;
        end
      end
      lo_r   <= t_lo;
      hi_r   <= t_hi;
      miss_r <= zmiss;
    end
  end

  // largest entry, smallest exit
  always_comb begin
    lo_max = lo_r;
    hi_min = hi_r;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      if (e_r[a] > lo_max) lo_max = e_r[a];
      if (x_r[a] < hi_min) hi_min = x_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1_r   <= lo_max;
      hi1_r   <= hi_min;
      miss1_r <= miss_r;
    end
  end

  assign hit = !miss1_r && (lo1_r < hi1_r);
endmodule

FILE: hdl/ray_box_slab_test.sv
// Top level: ray/box slab test with six divider lanes and a merge stage.
// Throughput: one box per cycle while not stalled; the six pipelined restoring divider
// lanes set the depth.
// The whole pipeline stalls together while a result waits on out_tready.
// Reset (rst_n low, synchronous) empties the pipeline and loads origin 0,
// direction (65536, 0, 0), which is (1.0, 0, 0) at Q16.16.
`timescale 1ns / 1ps
module ray_box_slab_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int CDW = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int AW  = (COORD_WIDTH > 32) ? 6 : 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, t_low, t_high
  input  logic [8*COORD_WIDTH-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // hit, zero padded
  output logic [7:0]               out_tdata,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [AW-1:0]            cfg_paddr,
  input  logic [CDW-1:0]           cfg_pwdata,
  output logic [CDW-1:0]           cfg_prdata,
  output logic                     cfg_pready
);
  localparam int W   = COORD_WIDTH;
  localparam int LAT = W + FRAC_BITS + 4;   // lane depth
  localparam int NA  = rbst_pkg::AXES;

  logic signed [W-1:0] origin_r [0:NA-1];
  logic signed [W-1:0] dir_r    [0:NA-1];
  logic [2:0]          reg_idx;
  logic                en;
  logic [LAT+1:0]      vld_r;
  logic                out_valid_r, hit_r, hit;

  logic signed [W-1:0] bmin [0:NA-1];
  logic signed [W-1:0] bmax [0:NA-1];
  logic signed [W-1:0] t_lo, t_hi;
  logic [NA-1:0]       dz;
  logic                zm;

  logic signed [W-1:0] tlo_d_r [0:LAT-1];
  logic signed [W-1:0] thi_d_r [0:LAT-1];
  logic [NA-1:0]       dz_d_r  [0:LAT-1];
  logic                zm_d_r  [0:LAT-1];
  logic signed [W-1:0] quot    [0:rbst_pkg::LANES-1];

  // configuration port
  assign reg_idx    = cfg_paddr[AW-1:AW-3];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        origin_r[a] <= '0;
        dir_r[a]    <= (a == 0) ? W'(65536) : '0;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_idx)
        rbst_pkg::REG_ORIGIN_X:    origin_r[0] <= W'(cfg_pwdata);
        rbst_pkg::REG_ORIGIN_Y:    origin_r[1] <= W'(cfg_pwdata);
        rbst_pkg::REG_ORIGIN_Z:    origin_r[2] <= W'(cfg_pwdata);
        rbst_pkg::REG_DIRECTION_X: dir_r[0]    <= W'(cfg_pwdata);
        rbst_pkg::REG_DIRECTION_Y: dir_r[1]    <= W'(cfg_pwdata);
        rbst_pkg::REG_DIRECTION_Z: dir_r[2]    <= W'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rbst_pkg::REG_ORIGIN_X:    cfg_prdata = CDW'($unsigned(origin_r[0]));
      rbst_pkg::REG_ORIGIN_Y:    cfg_prdata = CDW'($unsigned(origin_r[1]));
      rbst_pkg::REG_ORIGIN_Z:    cfg_prdata = CDW'($unsigned(origin_r[2]));
      rbst_pkg::REG_DIRECTION_X: cfg_prdata = CDW'($unsigned(dir_r[0]));
      rbst_pkg::REG_DIRECTION_Y: cfg_prdata = CDW'($unsigned(dir_r[1]));
      rbst_pkg::REG_DIRECTION_Z: cfg_prdata = CDW'($unsigned(dir_r[2]));
      default:                   cfg_prdata = '0;
    endcase
  end

  // pipeline advances unless a result is held
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // unpack input and check zero-direction axes
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      bmin[a] = in_tdata[a*W +: W];
      bmax[a] = in_tdata[(a+NA)*W +: W];
      dz[a]   = (dir_r[a] == '0);
    end
    t_lo = in_tdata[6*W +: W];
    t_hi = in_tdata[7*W +: W];
    zm   = 1'b0;
    for (int a = 0; a < NA; a++) begin
      if (dz[a] && (origin_r[a] < bmin[a] || origin_r[a] > bmax[a])) zm = 1'b1;
    end
  end

  // sideband delay matching the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      tlo_d_r[0] <= t_lo;
      thi_d_r[0] <= t_hi;
      dz_d_r[0]  <= dz;
      zm_d_r[0]  <= zm;
      for (int s = 1; s < LAT; s++) begin
        tlo_d_r[s] <= tlo_d_r[s-1];
        thi_d_r[s] <= thi_d_r[s-1];
        dz_d_r[s]  <= dz_d_r[s-1];
        zm_d_r[s]  <= zm_d_r[s-1];
      end
    end
  end

  // divider lanes: min corners then max corners
  for (genvar i = 0; i < rbst_pkg::LANES; i++) begin : g_lane
    rbst_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk       (clk),
      .en        (en),
      .corner    ((i < NA) ? bmin[i % NA] : bmax[i % NA]),
      .origin    (origin_r[i % NA]),
      .direction (dir_r[i % NA]),
      .quot      (quot[i])
    );
  end

  rbst_merge #(.W(W)) u_merge (
    .clk   (clk),
    .en    (en),
    .quot  (quot),
    .dzero (dz_d_r[LAT-1]),
    .zmiss (zm_d_r[LAT-1]),
    .t_lo  (tlo_d_r[LAT-1]),
    .t_hi  (thi_d_r[LAT-1]),
    .hit   (hit)
  );

  // valid tracking and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT:0], in_tvalid};
      out_valid_r <= vld_r[LAT+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) hit_r <= hit;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, hit_r};

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(hit_r))
    else $error("held result changed");
  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid_r && vld_r == '0)
    else $error("pipeline not empty after reset");
  // input is taken whenever the pipeline moves
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted transaction lost");
endmodule
